// File: rtl/dmac_pkg.sv
// ----------------------------------------------------------------------------
// dmac_pkg
// Shared codes and types of the four-channel DMA controller core.
// ----------------------------------------------------------------------------
package dmac_pkg;

  localparam int NUM_CHANNELS = 4;
  localparam int CHAN_W       = 2;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_DREQ  = 2'd2;
  localparam logic [1:0] FUNC_TICK  = 2'd3;

  localparam logic [3:0] MODE_ADDR = 4'd8;

  localparam logic [2:0] OP_WR_MODE = 3'd0;
  localparam logic [2:0] OP_WR_CHAN = 3'd1;
  localparam logic [2:0] OP_RD_STAT = 3'd2;
  localparam logic [2:0] OP_RD_CHAN = 3'd3;
  localparam logic [2:0] OP_DREQ    = 3'd4;
  localparam logic [2:0] OP_TICK    = 3'd5;

  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam int MODE_AUTOLOAD = 7;
  localparam int MODE_TC_STOP  = 6;
  localparam int STAT_UPDATE   = 4;

  typedef struct packed {
    logic [2:0]        op;
    logic [CHAN_W-1:0] chan;
    logic              sel_count;
    logic [7:0]        data;
    logic              level;
  } cmd_t;

endpackage

// File: rtl/dmac_front.sv
// ----------------------------------------------------------------------------
// dmac_front
// Accepts input items and classifies them into back-end commands.
// ----------------------------------------------------------------------------
module dmac_front (
  input  logic                  item_valid,
  output logic                  item_ready,
  input  logic [1:0]            func,
  input  logic [3:0]            reg_addr,
  input  logic [7:0]            wdata,
  input  logic [1:0]            dreq_channel,
  input  logic                  dreq_level,
  output logic                  push,
  output dmac_pkg::cmd_t        push_cmd,
  input  logic                  queue_full
);
  import dmac_pkg::*;

  always_comb begin
    push_cmd.chan      = reg_addr[2:1];
    push_cmd.sel_count = reg_addr[0];
    push_cmd.data      = wdata;
    push_cmd.level     = dreq_level;
    case (func)
      FUNC_WRITE: push_cmd.op = (reg_addr == MODE_ADDR) ? OP_WR_MODE : OP_WR_CHAN;
      FUNC_READ:  push_cmd.op = (reg_addr == MODE_ADDR) ? OP_RD_STAT : OP_RD_CHAN;
      FUNC_DREQ: begin
        push_cmd.op   = OP_DREQ;
        push_cmd.chan = dreq_channel;
      end
      default:    push_cmd.op = OP_TICK;
    endcase
  end

  assign item_ready = !queue_full;
  assign push       = item_valid && !queue_full;

endmodule

// File: rtl/dmac_queue.sv
// ----------------------------------------------------------------------------
// dmac_queue
// Four-entry command queue between the front and the back end.
// ----------------------------------------------------------------------------
module dmac_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dmac_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output dmac_pkg::cmd_t head
);
  import dmac_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  cmd_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   fill;

  assign full      = (fill == (PTR_W+1)'(DEPTH));
  assign not_empty = (fill != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: rtl/dmac_back.sv
// ----------------------------------------------------------------------------
// dmac_back
// Executes commands against the channel registers and issues results,
// one channel transfer per cycle on a tick while the result register is free.
// ----------------------------------------------------------------------------
module dmac_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  dmac_pkg::cmd_t cmd,
  output logic           pop,
  output logic           result_valid,
  input  logic           result_ready,
  output logic [7:0]     read_data,
  output logic           xfer_valid,
  output logic [1:0]     xfer_channel,
  output logic [1:0]     xfer_kind,
  output logic [15:0]    mem_address,
  output logic           terminal_count,
  output logic           last
);
  import dmac_pkg::*;

  logic [15:0]       chan_address [NUM_CHANNELS];
  logic [15:0]       chan_count   [NUM_CHANNELS];
  logic [1:0]        chan_direction [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] chan_active;
  logic [7:0]        mode_reg;
  logic [4:0]        status_reg;
  logic              byte_flipflop;

  logic              tick_busy;
  logic [NUM_CHANNELS-1:0] tick_mask;

  logic              slot_free;
  logic              needs_slot;
  logic              do_tick;
  logic              is_read;
  logic [NUM_CHANNELS-1:0] svc_mask;
  logic [NUM_CHANNELS-1:0] rem_mask;
  logic [CHAN_W-1:0] svc_c;
  logic [CHAN_W-1:0] sel_c;
  logic [15:0]       cur_addr;
  logic [15:0]       cur_count;
  logic [1:0]        cur_dir;
  logic              cnt_neg;
  logic [15:0]       cnt_after;
  logic              tc;
  logic              reload;
  logic [4:0]        status_next;
  logic [7:0]        rd_value;
  logic [7:0]        wr_byte;
  logic              mirror;

  function automatic logic [15:0] set_byte(logic [15:0] v, logic hi, logic [7:0] b);
    set_byte = hi ? {b, v[7:0]} : {v[15:8], b};
  endfunction

  always_comb begin
    slot_free  = !result_valid || result_ready;
    needs_slot = (cmd.op == OP_RD_STAT) || (cmd.op == OP_RD_CHAN) || (cmd.op == OP_TICK);
    pop        = !tick_busy && cmd_valid && (!needs_slot || slot_free);
    is_read    = pop && ((cmd.op == OP_RD_STAT) || (cmd.op == OP_RD_CHAN));
    svc_mask   = tick_busy ? tick_mask : chan_active;
    do_tick    = tick_busy ? slot_free
                           : (pop && (cmd.op == OP_TICK) && (chan_active != '0));
    if (svc_mask[0])      svc_c = 2'd0;
    else if (svc_mask[1]) svc_c = 2'd1;
    else if (svc_mask[2]) svc_c = 2'd2;
    else                  svc_c = 2'd3;
    rem_mask = svc_mask & (svc_mask - 1'b1);

    sel_c     = do_tick ? svc_c : cmd.chan;
    cur_addr  = chan_address[sel_c];
    cur_count = chan_count[sel_c];
    cur_dir   = chan_direction[sel_c];

    cnt_neg   = cur_count[15];
    cnt_after = cnt_neg ? cur_count : cur_count - 16'd1;
    tc        = cnt_after[15];
    reload    = tc && mode_reg[MODE_AUTOLOAD] && (svc_c == 2'd2);
    status_next = status_reg;
    if (!cnt_neg) status_next[STAT_UPDATE] = 1'b0;
    if (reload)   status_next[STAT_UPDATE] = 1'b1;
    if (tc)       status_next[svc_c] = 1'b1;

    if (cmd.op == OP_RD_STAT) begin
      rd_value = {3'b000, status_reg};
    end else if (cmd.sel_count) begin
      rd_value = byte_flipflop ? {cur_dir, cur_count[13:8]} : cur_count[7:0];
    end else begin
      rd_value = byte_flipflop ? cur_addr[15:8] : cur_addr[7:0];
    end

    wr_byte = (cmd.sel_count && byte_flipflop) ? {2'b00, cmd.data[5:0]} : cmd.data;
    mirror  = mode_reg[MODE_AUTOLOAD] && (cmd.chan == 2'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        chan_address[i]   <= '0;
        chan_count[i]     <= '0;
        chan_direction[i] <= '0;
      end
      chan_active   <= '0;
      mode_reg      <= '0;
      status_reg    <= '0;
      byte_flipflop <= 1'b0;
      tick_busy     <= 1'b0;
      tick_mask     <= '0;
    end else begin
      if (pop) begin
        case (cmd.op)
          OP_WR_MODE: begin
            if (!cmd.data[MODE_AUTOLOAD]) status_reg[STAT_UPDATE] <= 1'b0;
            mode_reg      <= cmd.data;
            byte_flipflop <= 1'b0;
          end
          OP_WR_CHAN: begin
            if (cmd.sel_count) begin
              if (mirror) chan_count[3] <= set_byte(chan_count[3], byte_flipflop, wr_byte);
              chan_count[cmd.chan] <= set_byte(cur_count, byte_flipflop, wr_byte);
              if (byte_flipflop) chan_direction[cmd.chan] <= cmd.data[7:6];
            end else begin
              if (mirror) chan_address[3] <= set_byte(chan_address[3], byte_flipflop, wr_byte);
              chan_address[cmd.chan] <= set_byte(cur_addr, byte_flipflop, wr_byte);
            end
            byte_flipflop <= !byte_flipflop;
          end
          OP_RD_STAT: status_reg <= status_reg & 5'h10;
          OP_RD_CHAN: byte_flipflop <= !byte_flipflop;
          OP_DREQ: begin
            if (cmd.level && mode_reg[cmd.chan]) begin
              status_reg[cmd.chan]  <= 1'b0;
              chan_active[cmd.chan] <= 1'b1;
            end else begin
              chan_active[cmd.chan] <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      if (do_tick) begin
        if (reload) begin
          chan_address[2] <= chan_address[3];
          chan_count[2]   <= chan_count[3];
        end else begin
          if (!cnt_neg) begin
            chan_address[svc_c] <= cur_addr + 16'd1;
            chan_count[svc_c]   <= cnt_after;
          end
          if (tc && mode_reg[MODE_TC_STOP]) mode_reg[svc_c] <= 1'b0;
        end
        if (tc) chan_active[svc_c] <= 1'b0;
        status_reg <= status_next;
        tick_busy  <= (rem_mask != '0);
        tick_mask  <= rem_mask;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (slot_free) begin
      result_valid <= do_tick || is_read;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      if (do_tick) begin
        read_data      <= 8'hff;
        xfer_valid     <= !cnt_neg;
        xfer_channel   <= svc_c;
        xfer_kind      <= cnt_neg ? KIND_NONE : cur_dir;
        mem_address    <= cur_addr;
        terminal_count <= tc;
        last           <= (rem_mask == '0);
      end else if (is_read) begin
        read_data      <= rd_value;
        xfer_valid     <= 1'b0;
        xfer_channel   <= '0;
        xfer_kind      <= KIND_NONE;
        mem_address    <= '0;
        terminal_count <= 1'b0;
        last           <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/four_channel_dma_controller_core.sv
// ----------------------------------------------------------------------------
// four_channel_dma_controller_core
// Four-channel DMA controller core in single-transfer mode.
// ----------------------------------------------------------------------------
// Items are register writes, register reads, request line changes and
// machine-cycle ticks. The front end decodes each item and places it in a
// four-entry queue, taking one item per cycle while the queue has room. The
// back end runs one queued command per cycle unless a tick is in progress or
// a read or tick waits for the result register; a write or request change
// gives no result, a read gives one result, and a tick gives one transfer
// result per active channel in channel order, one per cycle unless the
// output stalls, and none if no channel is active. Results leave through an
// output register; the last flag marks the final result of an item.
module four_channel_dma_controller_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [1:0]  func,
  input  logic [3:0]  reg_addr,
  input  logic [7:0]  wdata,
  input  logic [1:0]  dreq_channel,
  input  logic        dreq_level,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [7:0]  read_data,
  output logic        xfer_valid,
  output logic [1:0]  xfer_channel,
  output logic [1:0]  xfer_kind,
  output logic [15:0] mem_address,
  output logic        terminal_count,
  output logic        last
);
  import dmac_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic queue_full;
  logic pop;
  logic not_empty;
  cmd_t head;

  dmac_front u_front (
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .func        (func),
    .reg_addr    (reg_addr),
    .wdata       (wdata),
    .dreq_channel(dreq_channel),
    .dreq_level  (dreq_level),
    .push        (push),
    .push_cmd    (push_cmd),
    .queue_full  (queue_full)
  );

  dmac_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (queue_full),
    .pop      (pop),
    .not_empty(not_empty),
    .head     (head)
  );

  dmac_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (not_empty),
    .cmd           (head),
    .pop           (pop),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .read_data     (read_data),
    .xfer_valid    (xfer_valid),
    .xfer_channel  (xfer_channel),
    .xfer_kind     (xfer_kind),
    .mem_address   (mem_address),
    .terminal_count(terminal_count),
    .last          (last)
  );

endmodule
